@@ rtl/hsec_pkg.sv @@
// Shared constants for the Hamming single-error-correcting encoder/checker.
// No dependencies; compiled first.
package hsec_pkg;

  localparam int MAX_DATA_BITS_DEF   = 57;
  localparam int MAX_PARITY_BITS_DEF = 6;

  localparam int LEN_W = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd4;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_CHECK  = 1'b1;

endpackage

@@ rtl/hsec_if.sv @@
// Valid/ready channel interfaces for the Hamming encoder/checker items.
// Depends on hsec_pkg for default widths.
interface hsec_in_if #(
  parameter int DATA_W = hsec_pkg::MAX_DATA_BITS_DEF,
  parameter int CODE_W = hsec_pkg::MAX_DATA_BITS_DEF + hsec_pkg::MAX_PARITY_BITS_DEF
);
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] data;
  logic [CODE_W-1:0] codeword;

  modport source (output valid, kind, data, codeword, input ready);
  modport sink   (input valid, kind, data, codeword, output ready);
endinterface

interface hsec_out_if #(
  parameter int DATA_W = hsec_pkg::MAX_DATA_BITS_DEF,
  parameter int CODE_W = hsec_pkg::MAX_DATA_BITS_DEF + hsec_pkg::MAX_PARITY_BITS_DEF,
  parameter int SYN_W  = $clog2(CODE_W + 1)
);
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] codeword_out;
  logic [DATA_W-1:0] data_out;
  logic [SYN_W-1:0]  syndrome;
  logic              uncorrectable;

  modport source (output valid, codeword_out, data_out, syndrome, uncorrectable, input ready);
  modport sink   (input valid, codeword_out, data_out, syndrome, uncorrectable, output ready);
endinterface

@@ rtl/hamming_sec_encode_correct.sv @@
// Hamming SEC encoder and single-error corrector with a programmable message length.
// An item passes an input register, the parity/syndrome XOR trees, then a result register.
// Throughput: one item per cycle while out_ch is ready.
// Reset clears both stage valid flags and sets message length to 4 (7-bit code).
// Depends on hsec_pkg and the channel interfaces in hsec_if.sv.
module hamming_sec_encode_correct #(
  parameter int MAX_DATA_BITS   = hsec_pkg::MAX_DATA_BITS_DEF,
  parameter int MAX_PARITY_BITS = hsec_pkg::MAX_PARITY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hsec_pkg::LEN_W-1:0] cfg_wdata,
  hsec_in_if.sink                    in_ch,
  hsec_out_if.source                 out_ch
);
  import hsec_pkg::*;

  localparam int DATA_W = MAX_DATA_BITS;
  localparam int CODE_W = MAX_DATA_BITS + MAX_PARITY_BITS;
  localparam int SYN_W  = $clog2(CODE_W + 1);
  localparam int RCNT_W = $clog2(MAX_PARITY_BITS + 1);
  localparam int CMP_W  = LEN_W + 2;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] codeword;
  } item_t;

  function automatic bit is_pow2(input int p);
    return (p > 0) && ((p & (p - 1)) == 0);
  endfunction

  function automatic int data_pos(input int k);
    int c;
    int pos;
    c   = 0;
    pos = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (!is_pow2(p)) begin
        if (c == k && pos == 0) begin
          pos = p;
        end
        c++;
      end
    end
    return pos;
  endfunction

  function automatic logic [CODE_W-1:0] col_mask(input int j);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      m[p-1] = ((p >> j) & 1) == 1;
    end
    return m;
  endfunction

  function automatic logic [SYN_W-1:0] pos_xor(input logic [CODE_W-1:0] w);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int j = 0; j < SYN_W; j++) begin
      s[j] = ^(w & col_mask(j));
    end
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] m;
    m = v;
    if (v == '0) begin
      m = LEN_W'(1);
    end else if (v > LEN_W'(MAX_DATA_BITS)) begin
      m = LEN_W'(MAX_DATA_BITS);
    end
    return m;
  endfunction

  function automatic logic [RCNT_W-1:0] parity_count(input logic [LEN_W-1:0] m);
    logic [RCNT_W-1:0] r;
    r = RCNT_W'(1);
    for (int i = 1; i < MAX_PARITY_BITS; i++) begin
      if ((CMP_W'(1) << i) < (CMP_W'(m) + CMP_W'(i) + CMP_W'(1))) begin
        r = r + RCNT_W'(1);
      end
    end
    return r;
  endfunction

  logic [LEN_W-1:0]  m_r, m_nxt;
  logic [RCNT_W-1:0] r_r, r_nxt;
  logic [SYN_W-1:0]  n_r, n_nxt;

  item_t s1_r;
  logic  s1_valid_r;
  logic  out_valid_r;
  logic  adv;

  logic [CODE_W-1:0] word_r;
  logic [DATA_W-1:0] data_r;
  logic [SYN_W-1:0]  syn_r;
  logic              unc_r;

  logic [CODE_W-1:0] code_mask;
  logic [DATA_W-1:0] data_mask;
  logic [DATA_W-1:0] dm;
  logic [CODE_W-1:0] scat;
  logic [CODE_W-1:0] par_word;
  logic [CODE_W-1:0] enc_base;
  logic [CODE_W-1:0] enc_word;
  logic [SYN_W-1:0]  enc_syn;
  logic [CODE_W-1:0] chk_word;
  logic [CODE_W-1:0] flip_vec;
  logic [CODE_W-1:0] corr_word;
  logic [SYN_W-1:0]  chk_syn;
  logic              flip_ok;

  logic [CODE_W-1:0] word_nxt;
  logic [DATA_W-1:0] data_nxt;
  logic [SYN_W-1:0]  syn_nxt;
  logic              unc_nxt;

  always_comb begin
    m_nxt = clamp_len(cfg_wdata);
    r_nxt = parity_count(m_nxt);
    n_nxt = SYN_W'(m_nxt) + SYN_W'(r_nxt);
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      m_r         <= clamp_len(LEN_RESET);
      r_r         <= parity_count(clamp_len(LEN_RESET));
      n_r         <= SYN_W'(clamp_len(LEN_RESET)) + SYN_W'(parity_count(clamp_len(LEN_RESET)));
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_we) begin
        m_r <= m_nxt;
        r_r <= r_nxt;
        n_r <= n_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= '{kind: in_ch.kind, data: in_ch.data, codeword: in_ch.codeword};
    end
    if (adv && s1_valid_r) begin
      word_r <= word_nxt;
      data_r <= data_nxt;
      syn_r  <= syn_nxt;
      unc_r  <= unc_nxt;
    end
  end

  // Per-position wiring: data scatter, parity placement, error decode
  for (genvar p = 1; p <= CODE_W; p++) begin : g_pos
    assign code_mask[p-1] = SYN_W'(p) <= n_r;
    assign flip_vec[p-1]  = chk_syn == SYN_W'(p);
    if (is_pow2(p)) begin : g_par
      localparam int K = $clog2(p);
      assign scat[p-1]     = 1'b0;
      assign par_word[p-1] = enc_syn[K] && (SYN_W'(K) < SYN_W'(r_r));
    end else begin : g_dat
      localparam int K = data_pos(0) == 0 ? 0 : p - 1 - ($clog2(p + 1));
      assign par_word[p-1] = 1'b0;
      if (K < DATA_W) begin : g_in
        assign scat[p-1] = dm[K];
      end else begin : g_out
        assign scat[p-1] = 1'b0;
      end
    end
  end

  for (genvar k = 0; k < DATA_W; k++) begin : g_dbit
    localparam int P = data_pos(k);
    assign data_mask[k] = LEN_W'(k) < m_r;
    if (P != 0) begin : g_src
      assign data_nxt[k] = word_nxt[P-1];
    end else begin : g_none
      assign data_nxt[k] = 1'b0;
    end
  end

  assign dm        = s1_r.data & data_mask;
  assign enc_base  = scat & code_mask;
  assign enc_syn   = pos_xor(enc_base);
  assign enc_word  = enc_base | par_word;
  assign chk_word  = s1_r.codeword & code_mask;
  assign chk_syn   = pos_xor(chk_word);
  assign flip_ok   = (chk_syn != '0) && (chk_syn <= n_r);
  assign corr_word = flip_ok ? (chk_word ^ flip_vec) : chk_word;

  always_comb begin
    if (s1_r.kind == KIND_CHECK) begin
      word_nxt = corr_word;
      syn_nxt  = chk_syn;
      unc_nxt  = (chk_syn != '0) && (chk_syn > n_r);
    end else begin
      word_nxt = enc_word;
      syn_nxt  = '0;
      unc_nxt  = 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.codeword_out  = word_r;
  assign out_ch.data_out      = data_r;
  assign out_ch.syndrome      = syn_r;
  assign out_ch.uncorrectable = unc_r;

  a_unc_beyond_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && unc_r |-> syn_r > n_r)
    else $error("uncorrectable flagged with syndrome inside code length");

  a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !unc_r |-> pos_xor(word_r) == '0)
    else $error("result codeword has nonzero syndrome");

  a_high_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (word_r & ~code_mask) == '0)
    else $error("codeword bits beyond code length are set");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("item lost between input and result register");

endmodule
